// ----- rtl/dmarc_pkg.sv -----
// Package: shared types, codes and reset values of the DMA register controller.
`timescale 1ns / 1ps

package dmarc_pkg;

    // Default width of the wrapped memory address
    localparam int ADDR_BITS_DEF = 32;

    // Stream widths
    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 136;

    // Action codes carried on s_axis_tuser
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_SETUP = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    // Software register indexes
    localparam logic [2:0] REG_SRCHI   = 3'd0;
    localparam logic [2:0] REG_SRCLO   = 3'd1;
    localparam logic [2:0] REG_DSTHI   = 3'd2;
    localparam logic [2:0] REG_DSTLO   = 3'd3;
    localparam logic [2:0] REG_SIZE    = 3'd4;
    localparam logic [2:0] REG_SELECT  = 3'd5;
    localparam logic [2:0] REG_CONTROL = 3'd6;
    localparam logic [2:0] REG_GO      = 3'd7;

    // Configuration register indexes
    localparam logic [2:0] CFG_MEMORY_BASE = 3'd0;
    localparam logic [2:0] CFG_MEMORY_CODE = 3'd1;
    localparam logic [2:0] CFG_DISK_CODE   = 3'd2;
    localparam logic [2:0] CFG_CARD_CODE   = 3'd3;
    localparam logic [2:0] CFG_DELAY       = 3'd4;

    // Configuration reset values
    localparam logic [3:0] MEMORY_CODE_RST = 4'd0;
    localparam logic [3:0] DISK_CODE_RST   = 4'd1;
    localparam logic [3:0] CARD_CODE_RST   = 4'd2;
    localparam logic [7:0] DELAY_RST       = 8'd40;

    // Go register bits
    localparam int GO_START_BIT  = 0;
    localparam int GO_ENDIAN_BIT = 8;

    typedef struct packed {
        logic [31:0] memory_base;
        logic [3:0]  memory_code;
        logic [3:0]  disk_code;
        logic [3:0]  card_code;
        logic [7:0]  delay;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  reg_index;
        logic [31:0] write_value;
        logic [31:0] setup_offset;
        logic [31:0] setup_length;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        xfer_valid;
        logic        xfer_to_buffer;
        logic [31:0] mem_address;
        logic [31:0] buffer_offset;
        logic [31:0] xfer_length;
        logic        buffer_filled;
        logic        irq;
        logic        disk_ready;
    } result_t;

endpackage

// ----- rtl/dmarc_out_buf.sv -----
// Module: two-entry output buffer (result register plus skid register).
`timescale 1ns / 1ps

module dmarc_out_buf
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dmarc_pkg::result_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output dmarc_pkg::result_t out_data
);

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    dmarc_pkg::result_t out_data_reg;
    dmarc_pkg::result_t out_data_next;
    dmarc_pkg::result_t skid_data_reg;
    dmarc_pkg::result_t skid_data_next;
    logic               in_accept;

    assign in_ready  = !skid_valid_reg;
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Refill the result register from skid first, then from the input
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (in_accept)
            begin
                out_valid_next = 1'b1;
                out_data_next  = in_data;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ----- rtl/dmarc_core.sv -----
// Module: register file, transfer command logic and busy timer of the controller.
`timescale 1ns / 1ps

module dmarc_core
#(
    parameter int ADDR_BITS = dmarc_pkg::ADDR_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  dmarc_pkg::in_item_t item,
    input  dmarc_pkg::cfg_t     cfg,
    output dmarc_pkg::result_t  result
);

    // Address wrap mask, all ones once ADDR_BITS covers the 32-bit sum
    localparam logic [31:0] ADDR_MASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF
        : 32'((64'd1 << ADDR_BITS) - 64'd1);

    logic [31:0] source_offset_reg;
    logic [31:0] source_offset_next;
    logic [31:0] dest_offset_reg;
    logic [31:0] dest_offset_next;
    logic [31:0] byte_count_reg;
    logic [31:0] byte_count_next;
    logic [7:0]  device_select_reg;
    logic [7:0]  device_select_next;
    logic        endian_flag_reg;
    logic        endian_flag_next;
    logic        busy_reg;
    logic        busy_next;
    logic [7:0]  wait_ticks_reg;
    logic [7:0]  wait_ticks_next;
    logic [31:0] buffer_position_reg;
    logic [31:0] buffer_position_next;
    logic [31:0] buffer_length_reg;
    logic [31:0] buffer_length_next;

    logic [3:0]  src_code;
    logic        mem_hit;
    logic        dev_hit;
    logic [31:0] xfer_offset;
    logic [31:0] position_sum;
    logic [31:0] offset_sum;
    logic [31:0] addr_sum;

    // Decode the source device and form the shared adders
    assign src_code     = device_select_reg[7:4];
    assign mem_hit      = (src_code == cfg.memory_code);
    assign dev_hit      = (src_code == cfg.disk_code) || (src_code == cfg.card_code);
    assign xfer_offset  = mem_hit ? source_offset_reg : dest_offset_reg;
    assign position_sum = buffer_position_reg + byte_count_reg;
    assign offset_sum   = xfer_offset + byte_count_reg;
    assign addr_sum     = (cfg.memory_base + xfer_offset) & ADDR_MASK;

    // Compute the result and the next state for one transaction
    always_comb
    begin
        source_offset_next   = source_offset_reg;
        dest_offset_next     = dest_offset_reg;
        byte_count_next      = byte_count_reg;
        device_select_next   = device_select_reg;
        endian_flag_next     = endian_flag_reg;
        busy_next            = busy_reg;
        wait_ticks_next      = wait_ticks_reg;
        buffer_position_next = buffer_position_reg;
        buffer_length_next   = buffer_length_reg;
        result               = '0;

        case (item.action)
            dmarc_pkg::ACT_READ:
            begin
                case (item.reg_index)
                    dmarc_pkg::REG_SRCHI:   result.read_data = {16'd0, source_offset_reg[31:16]};
                    dmarc_pkg::REG_SRCLO:   result.read_data = {16'd0, source_offset_reg[15:0]};
                    dmarc_pkg::REG_DSTHI:   result.read_data = {16'd0, dest_offset_reg[31:16]};
                    dmarc_pkg::REG_DSTLO:   result.read_data = {16'd0, dest_offset_reg[15:0]};
                    dmarc_pkg::REG_SIZE:    result.read_data = byte_count_reg;
                    dmarc_pkg::REG_SELECT:  result.read_data = {24'd0, device_select_reg};
                    dmarc_pkg::REG_CONTROL:
                        result.read_data = {23'd0, endian_flag_reg, 7'd0, busy_reg};
                    default:                result.read_data = '0;
                endcase
            end
            dmarc_pkg::ACT_WRITE:
            begin
                case (item.reg_index)
                    dmarc_pkg::REG_SRCHI:
                        source_offset_next = {item.write_value[15:0], source_offset_reg[15:0]};
                    dmarc_pkg::REG_SRCLO:
                        source_offset_next = {source_offset_reg[31:16], item.write_value[15:0]};
                    dmarc_pkg::REG_DSTHI:
                        dest_offset_next = {item.write_value[15:0], dest_offset_reg[15:0]};
                    dmarc_pkg::REG_DSTLO:
                        dest_offset_next = {dest_offset_reg[31:16], item.write_value[15:0]};
                    dmarc_pkg::REG_SIZE:
                        byte_count_next = item.write_value;
                    dmarc_pkg::REG_SELECT:
                        device_select_next = item.write_value[7:0];
                    dmarc_pkg::REG_GO:
                    begin
                        endian_flag_next = item.write_value[dmarc_pkg::GO_ENDIAN_BIT];
                        // Issue a command when started and the source is known
                        if (item.write_value[dmarc_pkg::GO_START_BIT] && (mem_hit || dev_hit))
                        begin
                            result.xfer_valid     = 1'b1;
                            result.xfer_to_buffer = mem_hit;
                            result.mem_address    = addr_sum;
                            result.buffer_offset  = buffer_position_reg;
                            result.xfer_length    = byte_count_reg;
                            result.buffer_filled  = mem_hit && (position_sum >= buffer_length_reg);
                            buffer_position_next  = position_sum;
                            busy_next             = 1'b1;
                            if (mem_hit)
                            begin
                                source_offset_next = offset_sum;
                            end
                            else
                            begin
                                dest_offset_next = offset_sum;
                            end
                        end
                    end
                    default:
                    begin
                        // Control and unknown indexes: drop the write
                    end
                endcase
            end
            dmarc_pkg::ACT_SETUP:
            begin
                buffer_position_next = item.setup_offset;
                buffer_length_next   = item.setup_length;
            end
            dmarc_pkg::ACT_TICK:
            begin
                // Count busy ticks and complete once past the delay
                if (busy_reg)
                begin
                    if (wait_ticks_reg >= cfg.delay)
                    begin
                        busy_next         = 1'b0;
                        wait_ticks_next   = '0;
                        result.irq        = 1'b1;
                        result.disk_ready = (buffer_position_reg >= buffer_length_reg);
                    end
                    else
                    begin
                        wait_ticks_next = wait_ticks_reg + 8'd1;
                    end
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    // Advance state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_offset_reg   <= '0;
            dest_offset_reg     <= '0;
            byte_count_reg      <= '0;
            device_select_reg   <= '0;
            endian_flag_reg     <= 1'b0;
            busy_reg            <= 1'b0;
            wait_ticks_reg      <= '0;
            buffer_position_reg <= '0;
            buffer_length_reg   <= '0;
        end
        else if (accept)
        begin
            source_offset_reg   <= source_offset_next;
            dest_offset_reg     <= dest_offset_next;
            byte_count_reg      <= byte_count_next;
            device_select_reg   <= device_select_next;
            endian_flag_reg     <= endian_flag_next;
            busy_reg            <= busy_next;
            wait_ticks_reg      <= wait_ticks_next;
            buffer_position_reg <= buffer_position_next;
            buffer_length_reg   <= buffer_length_next;
        end
    end

endmodule

// ----- rtl/dma_register_controller.sv -----
// All work is one pass of logic into the result register, or into the skid register on a stall.
// Throughput: one transaction per cycle while the skid register is empty (s_axis_tready high).
// A skid register behind the result register keeps s_axis_tready high for one stalled result.
// Reset (rst_n low, asynchronous) clears all state and loads the configuration defaults:
// memory base 0, device codes 0/1/2, completion delay 40; both output stages empty.
`timescale 1ns / 1ps

module dma_register_controller
#(
    parameter int ADDR_BITS = dmarc_pkg::ADDR_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [2:0]                      cfg_index,
    input  logic [31:0]                     cfg_data,
    // Input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: reg_index[2:0], write_value[34:3], setup_offset[66:35],
    //        setup_length[98:67], zero pad[103:99]
    input  logic [dmarc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: action[1:0]
    input  logic [dmarc_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // Output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: read_data[31:0], xfer_valid[32], xfer_to_buffer[33], mem_address[65:34],
    //        buffer_offset[97:66], xfer_length[129:98], buffer_filled[130], irq[131],
    //        disk_ready[132], zero pad[135:133]
    output logic [dmarc_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    dmarc_pkg::cfg_t     cfg_reg;
    dmarc_pkg::cfg_t     cfg_next;
    dmarc_pkg::in_item_t item;
    dmarc_pkg::result_t  result;
    dmarc_pkg::result_t  out_data;
    logic                in_accept;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                dmarc_pkg::CFG_MEMORY_BASE: cfg_next.memory_base = cfg_data;
                dmarc_pkg::CFG_MEMORY_CODE: cfg_next.memory_code = cfg_data[3:0];
                dmarc_pkg::CFG_DISK_CODE:   cfg_next.disk_code   = cfg_data[3:0];
                dmarc_pkg::CFG_CARD_CODE:   cfg_next.card_code   = cfg_data[3:0];
                dmarc_pkg::CFG_DELAY:       cfg_next.delay       = cfg_data[7:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.memory_base <= '0;
            cfg_reg.memory_code <= dmarc_pkg::MEMORY_CODE_RST;
            cfg_reg.disk_code   <= dmarc_pkg::DISK_CODE_RST;
            cfg_reg.card_code   <= dmarc_pkg::CARD_CODE_RST;
            cfg_reg.delay       <= dmarc_pkg::DELAY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Unpack the input transaction
    assign in_accept         = s_axis_tvalid && s_axis_tready;
    assign item.action       = s_axis_tuser;
    assign item.reg_index    = s_axis_tdata[2:0];
    assign item.write_value  = s_axis_tdata[34:3];
    assign item.setup_offset = s_axis_tdata[66:35];
    assign item.setup_length = s_axis_tdata[98:67];

    dmarc_core
    #(
        .ADDR_BITS (ADDR_BITS)
    )
    u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_accept),
        .item   (item),
        .cfg    (cfg_reg),
        .result (result)
    );

    dmarc_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    // Pack the result transaction
    assign m_axis_tdata = {3'd0,
                           out_data.disk_ready,
                           out_data.irq,
                           out_data.buffer_filled,
                           out_data.xfer_length,
                           out_data.buffer_offset,
                           out_data.mem_address,
                           out_data.xfer_to_buffer,
                           out_data.xfer_valid,
                           out_data.read_data};

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the DMA register controller stream interface.
`timescale 1ns / 1ps

module testbench;

    // Track the controller's registers and queue the result each request must produce
    class dma_scoreboard;
        // configuration
        logic [31:0] mem_base;
        logic [3:0]  mem_code;
        logic [3:0]  disk_code;
        logic [3:0]  card_code;
        logic [7:0]  done_delay;
        // software-visible and internal state
        logic [31:0] src_off;
        logic [31:0] dst_off;
        logic [31:0] byte_count;
        logic [7:0]  dev_select;
        logic        endian;
        logic        busy;
        logic [7:0]  wait_ticks;
        logic [31:0] buf_pos;
        logic [31:0] buf_len;
        dmarc_pkg::result_t expected_results[$];
        int          errors;

        function new();
            mem_base   = '0;
            mem_code   = dmarc_pkg::MEMORY_CODE_RST;
            disk_code  = dmarc_pkg::DISK_CODE_RST;
            card_code  = dmarc_pkg::CARD_CODE_RST;
            done_delay = dmarc_pkg::DELAY_RST;
            src_off    = '0;
            dst_off    = '0;
            byte_count = '0;
            dev_select = '0;
            endian     = 1'b0;
            busy       = 1'b0;
            wait_ticks = '0;
            buf_pos    = '0;
            buf_len    = '0;
            errors     = 0;
        endfunction

        function void write_config(logic [2:0] index, logic [31:0] value);
            case (index)
                dmarc_pkg::CFG_MEMORY_BASE: mem_base   = value;
                dmarc_pkg::CFG_MEMORY_CODE: mem_code   = value[3:0];
                dmarc_pkg::CFG_DISK_CODE:   disk_code  = value[3:0];
                dmarc_pkg::CFG_CARD_CODE:   card_code  = value[3:0];
                dmarc_pkg::CFG_DELAY:       done_delay = value[7:0];
                default: ;
            endcase
        endfunction

        // Advance the state by one accepted request and queue its result
        function void note_request(dmarc_pkg::in_item_t req);
            dmarc_pkg::result_t res;
            logic [3:0]         src_dev;
            res = '0;
            case (req.action)
                dmarc_pkg::ACT_READ:
                begin
                    case (req.reg_index)
                        dmarc_pkg::REG_SRCHI:   res.read_data = {16'h0, src_off[31:16]};
                        dmarc_pkg::REG_SRCLO:   res.read_data = {16'h0, src_off[15:0]};
                        dmarc_pkg::REG_DSTHI:   res.read_data = {16'h0, dst_off[31:16]};
                        dmarc_pkg::REG_DSTLO:   res.read_data = {16'h0, dst_off[15:0]};
                        dmarc_pkg::REG_SIZE:    res.read_data = byte_count;
                        dmarc_pkg::REG_SELECT:  res.read_data = {24'h0, dev_select};
                        dmarc_pkg::REG_CONTROL: res.read_data = {23'h0, endian, 7'h0, busy};
                        default:                res.read_data = '0;
                    endcase
                end
                dmarc_pkg::ACT_WRITE:
                begin
                    case (req.reg_index)
                        dmarc_pkg::REG_SRCHI:  src_off[31:16] = req.write_value[15:0];
                        dmarc_pkg::REG_SRCLO:  src_off[15:0]  = req.write_value[15:0];
                        dmarc_pkg::REG_DSTHI:  dst_off[31:16] = req.write_value[15:0];
                        dmarc_pkg::REG_DSTLO:  dst_off[15:0]  = req.write_value[15:0];
                        dmarc_pkg::REG_SIZE:   byte_count     = req.write_value;
                        dmarc_pkg::REG_SELECT: dev_select     = req.write_value[7:0];
                        dmarc_pkg::REG_GO:
                        begin
                            endian  = req.write_value[dmarc_pkg::GO_ENDIAN_BIT];
                            src_dev = dev_select[7:4];
                            if (req.write_value[dmarc_pkg::GO_START_BIT])
                            begin
                                // memory code takes priority over disk and card codes
                                if (src_dev == mem_code)
                                begin
                                    res.xfer_valid     = 1'b1;
                                    res.xfer_to_buffer = 1'b1;
                                    res.mem_address    = mem_base + src_off;
                                    res.buffer_offset  = buf_pos;
                                    res.xfer_length    = byte_count;
                                    buf_pos            = buf_pos + byte_count;
                                    src_off            = src_off + byte_count;
                                    res.buffer_filled  = (buf_pos >= buf_len);
                                    busy               = 1'b1;
                                end
                                else if (src_dev == disk_code || src_dev == card_code)
                                begin
                                    res.xfer_valid     = 1'b1;
                                    res.mem_address    = mem_base + dst_off;
                                    res.buffer_offset  = buf_pos;
                                    res.xfer_length    = byte_count;
                                    buf_pos            = buf_pos + byte_count;
                                    dst_off            = dst_off + byte_count;
                                    busy               = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                dmarc_pkg::ACT_SETUP:
                begin
                    buf_pos = req.setup_offset;
                    buf_len = req.setup_length;
                end
                default:
                begin
                    // count ticks only while busy
                    if (busy)
                    begin
                        if (wait_ticks >= done_delay)
                        begin
                            busy           = 1'b0;
                            wait_ticks     = '0;
                            res.irq        = 1'b1;
                            res.disk_ready = (buf_pos >= buf_len);
                        end
                        else
                            wait_ticks = wait_ticks + 8'd1;
                    end
                end
            endcase
            expected_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %h, got %h", name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result against the oldest pending one
        function void check_result(logic [dmarc_pkg::M_TDATA_W-1:0] tdata);
            dmarc_pkg::result_t want;
            if (expected_results.size() == 0)
            begin
                $error("result %h arrived with nothing pending", tdata);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("read_data", want.read_data, tdata[31:0]);
            compare_field("xfer_valid", 32'(want.xfer_valid), 32'(tdata[32]));
            compare_field("xfer_to_buffer", 32'(want.xfer_to_buffer), 32'(tdata[33]));
            compare_field("mem_address", want.mem_address, tdata[65:34]);
            compare_field("buffer_offset", want.buffer_offset, tdata[97:66]);
            compare_field("xfer_length", want.xfer_length, tdata[129:98]);
            compare_field("buffer_filled", 32'(want.buffer_filled), 32'(tdata[130]));
            compare_field("irq", 32'(want.irq), 32'(tdata[131]));
            compare_field("disk_ready", 32'(want.disk_ready), 32'(tdata[132]));
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [2:0]                        cfg_index = '0;
    logic [31:0]                       cfg_data = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [dmarc_pkg::S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [dmarc_pkg::S_TUSER_W-1:0]   s_axis_tuser = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [dmarc_pkg::M_TDATA_W-1:0]   m_axis_tdata;

    // suppress random idling on both sides while set
    bit                     steady = 1'b0;
    dma_scoreboard          sb = new();

    dma_register_controller dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic dmarc_pkg::in_item_t make_request(logic [1:0] act, logic [2:0] index,
                                                         logic [31:0] value,
                                                         logic [31:0] offset,
                                                         logic [31:0] length);
        dmarc_pkg::in_item_t req;
        req.action       = act;
        req.reg_index    = index;
        req.write_value  = value;
        req.setup_offset = offset;
        req.setup_length = length;
        return req;
    endfunction

    // Draw one random request, biased toward sequences that start and finish transfers
    function automatic dmarc_pkg::in_item_t random_request(int tick_pct);
        dmarc_pkg::in_item_t req;
        int                  roll;
        req.action       = dmarc_pkg::ACT_WRITE;
        req.reg_index    = 3'($urandom_range(0, 7));
        req.write_value  = $urandom;
        req.setup_offset = $urandom;
        req.setup_length = $urandom;
        if ($urandom_range(0, 99) < tick_pct)
            req.action = dmarc_pkg::ACT_TICK;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 20)
                req.action = dmarc_pkg::ACT_READ;
            else if (roll < 30)
            begin
                req.action = dmarc_pkg::ACT_SETUP;
                if ($urandom_range(0, 4) != 0)
                begin
                    req.setup_offset = $urandom_range(0, 255);
                    req.setup_length = $urandom_range(0, 511);
                end
            end
            else if (roll < 50)
            begin
                req.reg_index = dmarc_pkg::REG_GO;
                req.write_value[dmarc_pkg::GO_START_BIT] = ($urandom_range(0, 5) != 0);
            end
            else if (roll < 65)
            begin
                req.reg_index = dmarc_pkg::REG_SELECT;
                case ($urandom_range(0, 3))
                    0:       req.write_value[7:4] = sb.mem_code;
                    1:       req.write_value[7:4] = sb.disk_code;
                    2:       req.write_value[7:4] = sb.card_code;
                    default: req.write_value[7:4] = 4'($urandom_range(0, 15));
                endcase
            end
            else if (roll < 75)
            begin
                req.reg_index = dmarc_pkg::REG_SIZE;
                if ($urandom_range(0, 4) != 0)
                    req.write_value = $urandom_range(0, 64);
            end
        end
        return req;
    endfunction

    // Present one request and hold it until the transaction completes
    task automatic send_request(input dmarc_pkg::in_item_t req);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req.action;
        s_axis_tdata  <= {5'b0, req.setup_length, req.setup_offset, req.write_value,
                          req.reg_index};
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        sb.note_request(req);
    endtask

    // Drop valid and wait until every pending result has been taken
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Write all configuration registers back to back
    task automatic load_config(input logic [31:0] base, input logic [3:0] mc,
                               input logic [3:0] dc, input logic [3:0] cc,
                               input logic [7:0] dly);
        logic [2:0]  indexes [5];
        logic [31:0] values [5];
        int          k;
        indexes = '{dmarc_pkg::CFG_MEMORY_BASE, dmarc_pkg::CFG_MEMORY_CODE,
                    dmarc_pkg::CFG_DISK_CODE, dmarc_pkg::CFG_CARD_CODE,
                    dmarc_pkg::CFG_DELAY};
        values  = '{base, {28'h0, mc}, {28'h0, dc}, {28'h0, cc}, {24'h0, dly}};
        for (k = 0; k < 5; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= indexes[k];
            cfg_data  <= values[k];
            do @(posedge clk); while (cfg_ready !== 1'b1);
            sb.write_config(indexes[k], values[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [31:0] base, input logic [3:0] mc,
                             input logic [3:0] dc, input logic [3:0] cc,
                             input logic [7:0] dly, input int count, input int tick_pct);
        int n;
        drain();
        load_config(base, mc, dc, cc, dly);
        for (n = 0; n < count; n++)
        begin
            // alternate stretches with and without idling
            if (n % 40 == 0)
                steady = ($urandom_range(0, 3) == 0);
            send_request(random_request(tick_pct));
        end
    endtask

    // Stimulus
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // base near the top so the first memory address wraps; short completion delay
        load_config(32'hFFFF_FFF0, 4'd0, 4'd1, 4'd2, 8'd1);
        send_request(make_request(dmarc_pkg::ACT_WRITE, dmarc_pkg::REG_SRCHI,
                                  32'hFFFF_ABCD, '0, '0));
        send_request(make_request(dmarc_pkg::ACT_WRITE, dmarc_pkg::REG_SRCLO,
                                  32'hFFFF_1234, '0, '0));
        send_request(make_request(dmarc_pkg::ACT_WRITE, dmarc_pkg::REG_DSTHI,
                                  32'h0000_8000, '0, '0));
        send_request(make_request(dmarc_pkg::ACT_WRITE, dmarc_pkg::REG_DSTLO,
                                  32'hFFFF_FFFF, '0, '0));
        send_request(make_request(dmarc_pkg::ACT_WRITE, dmarc_pkg::REG_SIZE,
                                  32'hFFFF_FFFF, '0, '0));
        send_request(make_request(dmarc_pkg::ACT_WRITE, dmarc_pkg::REG_SELECT,
                                  32'hFFFF_FF0F, '0, '0));
        // control writes are ignored
        send_request(make_request(dmarc_pkg::ACT_WRITE, dmarc_pkg::REG_CONTROL,
                                  32'hFFFF_FFFF, '0, '0));
        for (int r = 0; r < 8; r++)
            send_request(make_request(dmarc_pkg::ACT_READ, r[2:0], '0, '0, '0));
        send_request(make_request(dmarc_pkg::ACT_SETUP, dmarc_pkg::REG_SRCHI,
                                  '0, 32'hFFFF_FFF0, 32'hFFFF_FFFF));
        // go without start bit only updates the endian flag
        send_request(make_request(dmarc_pkg::ACT_WRITE, dmarc_pkg::REG_GO,
                                  32'h0000_0100, '0, '0));
        // memory to buffer with offset and address overflow
        send_request(make_request(dmarc_pkg::ACT_WRITE, dmarc_pkg::REG_GO,
                                  32'hFFFF_FFFF, '0, '0));
        send_request(make_request(dmarc_pkg::ACT_READ, dmarc_pkg::REG_CONTROL,
                                  '0, '0, '0));
        send_request(make_request(dmarc_pkg::ACT_TICK, dmarc_pkg::REG_SRCHI,
                                  '0, '0, '0));
        send_request(make_request(dmarc_pkg::ACT_TICK, dmarc_pkg::REG_GO,
                                  32'hFFFF_FFFF, '1, '1));
        // tick while idle
        send_request(make_request(dmarc_pkg::ACT_TICK, dmarc_pkg::REG_SRCHI,
                                  '0, '0, '0));
        // disk then card source, second go while busy
        send_request(make_request(dmarc_pkg::ACT_WRITE, dmarc_pkg::REG_SELECT,
                                  32'h0000_0010, '0, '0));
        send_request(make_request(dmarc_pkg::ACT_WRITE, dmarc_pkg::REG_GO,
                                  32'h0000_0001, '0, '0));
        send_request(make_request(dmarc_pkg::ACT_WRITE, dmarc_pkg::REG_SELECT,
                                  32'h0000_002F, '0, '0));
        send_request(make_request(dmarc_pkg::ACT_WRITE, dmarc_pkg::REG_GO,
                                  32'h0000_0001, '0, '0));
        // unknown source nibble issues nothing
        send_request(make_request(dmarc_pkg::ACT_WRITE, dmarc_pkg::REG_SELECT,
                                  32'h0000_00F0, '0, '0));
        send_request(make_request(dmarc_pkg::ACT_WRITE, dmarc_pkg::REG_GO,
                                  32'h0000_0001, '0, '0));

        run_phase($urandom, 4'd0, 4'd1, 4'd2, 8'd3, 300, 35);
        // every code equal: memory wins
        run_phase(32'hFFFF_FFFF, 4'd15, 4'd15, 4'd15, 8'd1, 250, 30);
        // longest delay, tick heavy
        run_phase(32'h0000_0000, 4'd5, 4'd5, 4'd9, 8'd255, 400, 85);
        run_phase($urandom, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)), 8'($urandom_range(1, 16)), 300, 40);
        run_phase($urandom, 4'd0, 4'd15, 4'd7, dmarc_pkg::DELAY_RST, 300, 60);
        run_phase($urandom, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)), 8'($urandom_range(1, 10)), 270, 40);

        drain();
        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Result side: stall at random, then take and check one transaction
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (m_axis_tvalid !== 1'b1);
            sb.check_result(m_axis_tdata);
        end
    end

    // Watchdog
    initial
    begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
